// ===== hdl/ieel_pkg.sv =====
// shared types, sizes and codes for the indexed insert/erase list
package ieel_pkg;

    // list geometry
    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 6;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // field widths
    localparam int MODE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

    // per-cell load select
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOW,
        SEL_HIGH,
        SEL_WORD
    } t_cell_sel;

endpackage

// ===== hdl/indexed_insert_erase_list.sv =====
// top level of the indexed insert/erase list: control, cell chain and result register
//
// Bounded ordered list of signed 32-bit words held in a row of DEPTH cells.
// The list is stored tail first: cell 0 holds the last entry, so push and
// pop shift the whole row, and insert and erase shift only the cells past
// a boundary index that is broadcast to every cell.
// Input channel (s): one request per transfer, tdata carries mode, position
// and the word. Output channel (m): one result per request, tdata carries
// the removed word, the new count and a status.
// Result: valid in the cycle after the request is taken.
// Throughput: one request per cycle while the output register is not
// stalled; every cell loads from itself, a neighbor or the word in the same cycle.
// Stall: the result sits in the output register while o_m_tvalid is high
// and i_m_tready is low; a new request is taken only in a cycle where that
// register is empty or being emptied.
// Reset: the count goes to zero and the output register empties; the
// stored words are not cleared and are never read before being written.
module indexed_insert_erase_list
    import ieel_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [2:0] mode, [8:3] position, [40:9] word_in, [47:41] zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [31:0] word_out, [38:32] count, [40:39] status, [47:41] zero
    output logic [M_DATA_W-1:0] o_m_tdata
);

    // request fields
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;

    assign mode     = i_s_tdata[MODE_W-1:0];
    assign position = i_s_tdata[MODE_W+POS_W-1:MODE_W];
    assign word_in  = i_s_tdata[MODE_W+POS_W+WORD_W-1:MODE_W+POS_W];

    // state
    logic [CNT_W-1:0]           r_fill;
    logic [CNT_W-1:0]           n_fill;
    logic                       r_m_valid;
    logic                       n_m_valid;
    logic signed [WORD_W-1:0]   r_word_out;
    logic signed [WORD_W-1:0]   n_word_out;
    logic [COUNT_W-1:0]         r_count;
    logic [COUNT_W-1:0]         n_count;
    logic [STATUS_W-1:0]        r_status;
    logic [STATUS_W-1:0]        n_status;

    logic                       accept;
    logic                       go_up;
    logic                       go_down;
    logic [IDX_W-1:0]           thr;
    logic [CMP_W-1:0]           fill_x;
    logic [CMP_W-1:0]           pos_x;
    logic signed [WORD_W-1:0]   q [DEPTH];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign fill_x     = CMP_W'(r_fill);
    assign pos_x      = CMP_W'(position);

    // operation decode and status
    always_comb begin
        n_fill     = r_fill;
        n_word_out = '0;
        n_status   = ST_OK;
        go_up      = 1'b0;
        go_down    = 1'b0;
        thr        = '0;
        case (mode)
            MODE_PUSH: begin
                if (r_fill >= CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    go_up  = 1'b1;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            MODE_POP: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    go_down    = 1'b1;
                    n_word_out = q[0];
                    n_fill     = r_fill - CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                if (pos_x >= fill_x) begin
                    n_status = ST_INDEX;
                end else if (r_fill >= CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    go_up  = 1'b1;
                    thr    = IDX_W'(fill_x - pos_x);
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            MODE_ERASE: begin
                if (pos_x >= fill_x) begin
                    n_status = ST_INDEX;
                end else begin
                    go_down = 1'b1;
                    thr     = IDX_W'(fill_x - pos_x - CMP_W'(1));
                    n_fill  = r_fill - CNT_W'(1);
                end
            end
            MODE_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
        n_count = COUNT_W'(n_fill);
    end

    // cell chain
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_sel                sel;
        logic signed [WORD_W-1:0] low;
        logic signed [WORD_W-1:0] high;

        if (k == 0) begin : g_first
            assign low = '0;
        end else begin : g_mid_low
            assign low = q[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign high = '0;
        end else begin : g_mid_high
            assign high = q[k+1];
        end

        // boundary compare against the broadcast index
        always_comb begin
            sel = SEL_HOLD;
            if (accept && go_up) begin
                if (IDX_W'(k) > thr) begin
                    sel = SEL_LOW;
                end else if (IDX_W'(k) == thr) begin
                    sel = SEL_WORD;
                end
            end else if (accept && go_down) begin
                if (IDX_W'(k) >= thr) begin
                    sel = SEL_HIGH;
                end
            end
        end

        ieel_cell u_cell (
            .i_clk  (i_clk),
            .i_sel  (sel),
            .i_word (word_in),
            .i_low  (low),
            .i_high (high),
            .o_q    (q[k])
        );
    end

    // output valid next value
    always_comb begin
        n_m_valid = r_m_valid;
        if (accept) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word_out <= n_word_out;
            r_count    <= n_count;
            r_status   <= n_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_DATA_W - WORD_W - COUNT_W - STATUS_W){1'b0}},
                         r_status, r_count, r_word_out};

endmodule

// ===== hdl/ieel_cell.sv =====
// one storage cell of the list chain: holds its word, loads the input word or takes one from a neighbor
module ieel_cell
    import ieel_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_sel                i_sel,
    input  logic signed [WORD_W-1:0] i_word,
    input  logic signed [WORD_W-1:0] i_low,
    input  logic signed [WORD_W-1:0] i_high,
    output logic signed [WORD_W-1:0] o_q
);

    logic signed [WORD_W-1:0] r_q;
    logic signed [WORD_W-1:0] n_q;

    // load select
    always_comb begin
        case (i_sel)
            SEL_LOW:  n_q = i_low;
            SEL_HIGH: n_q = i_high;
            SEL_WORD: n_q = i_word;
            default:  n_q = r_q;
        endcase
    end

    // word register
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== hdl/ieel_checker.sv =====
// port-level checker for the indexed insert/erase list, bound to the top level
module ieel_checker
    import ieel_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata
);

    logic [WORD_W-1:0]   word_out;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;

    assign word_out = o_m_tdata[WORD_W-1:0];
    assign count    = o_m_tdata[WORD_W+COUNT_W-1:WORD_W];
    assign status   = o_m_tdata[WORD_W+COUNT_W+STATUS_W-1:WORD_W+COUNT_W];

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a request always yields a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("request without result");

    // a refused request returns a zero word
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && status != ST_OK |-> word_out == '0)
        else $error("word returned on a refused request");

    // full and empty flags agree with the count
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (status == ST_FULL || status == ST_EMPTY) |->
            ((status == ST_FULL && count == COUNT_W'(DEPTH)) ||
             (status == ST_EMPTY && count == '0)))
        else $error("status does not match count");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind indexed_insert_erase_list ieel_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
// testbench for the indexed insert/erase list: directed, full-list and random request streams
module tb;
    import ieel_pkg::*;

    // spare mode codes, the block treats them as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

    localparam int S_PAD_W    = S_DATA_W - MODE_W - POS_W - WORD_W;
    localparam int RUN_LIMIT  = 2000000;
    localparam int DRAIN_MAX  = 5000;
    localparam int TAIL_WAIT  = 4;

    typedef struct packed {
        logic signed [WORD_W-1:0]   word;
        logic        [COUNT_W-1:0]  count;
        logic        [STATUS_W-1:0] status;
    } t_list_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // [2:0] mode, [8:3] position, [40:9] word_in, [47:41] zero
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [31:0] word_out, [38:32] count, [40:39] status, [47:41] zero
    logic [M_DATA_W-1:0] o_m_tdata;

    // predicted list contents and fill level
    logic [WORD_W-1:0]   list_words [DEPTH];
    int                  list_fill;

    t_list_result        pending_results [$];
    int                  mismatch_count;
    int                  mode_hits   [8];
    int                  status_hits [4];
    int                  full_hits;
    int                  burst_left;

    int                  ready_phase;
    int                  ready_phase_left;

    indexed_insert_erase_list u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock, period 4
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // list predictor: applies one request and returns the result it should give
    function automatic t_list_result apply_list_op(input logic [MODE_W-1:0] mode,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] word);
        t_list_result res;
        int           idx;
        res.word   = '0;
        res.status = ST_OK;
        idx        = int'(pos);
        case (mode)
            MODE_PUSH: begin
                if (list_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_fill] = word;
                    list_fill++;
                end
            end
            MODE_POP: begin
                if (list_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_fill--;
                    res.word = list_words[list_fill];
                end
            end
            MODE_INSERT: begin
                // index check comes before the full check
                if (idx >= list_fill) begin
                    res.status = ST_INDEX;
                end else if (list_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_fill; k > idx; k--)
                        list_words[k] = list_words[k-1];
                    list_words[idx] = word;
                    list_fill++;
                end
            end
            MODE_ERASE: begin
                if (idx >= list_fill) begin
                    res.status = ST_INDEX;
                end else begin
                    list_fill--;
                    for (int k = idx; k < list_fill; k++)
                        list_words[k] = list_words[k+1];
                end
            end
            MODE_CLEAR: begin
                list_fill = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(list_fill);
        status_hits[res.status]++;
        if (list_fill == DEPTH && (mode == MODE_PUSH || mode == MODE_INSERT)
            && res.status == ST_OK)
            full_hits++;
        return res;
    endfunction

    // send one request, record its prediction, then idle per the burst pattern
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word);
        i_s_tdata  = {{S_PAD_W{1'b0}}, word, pos, mode};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_list_op(mode, pos, word));
        mode_hits[mode]++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            // now and then a long burst with no gaps
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // random word, with the extremes mixed in
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // index mostly inside the list, sometimes on or past its end
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5 && list_fill > 0)
            return POS_W'($urandom_range(0, list_fill - 1));
        else if (r == 6 && list_fill > 0)
            return POS_W'(list_fill - 1);
        else if (r == 7 && list_fill < DEPTH)
            return POS_W'(list_fill);
        else if (r == 8)
            return {POS_W{1'b1}};
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // corner requests on a small list
    task automatic test_directed_corners();
        send_request(MODE_POP,     6'd0,  32'h1234_5678);
        send_request(MODE_ERASE,   6'd0,  32'h0);
        send_request(MODE_INSERT,  6'd0,  32'h0BAD_F00D);
        send_request(MODE_PUSH,    6'd0,  32'h7FFF_FFFF);
        send_request(MODE_PUSH,    6'd63, 32'h8000_0000);
        send_request(MODE_INSERT,  6'd0,  32'h0000_0000);
        send_request(MODE_INSERT,  6'd2,  32'hFFFF_FFFF);
        send_request(MODE_INSERT,  6'd4,  32'h1111_1111);
        send_request(MODE_ERASE,   6'd63, 32'h0);
        send_request(MODE_ERASE,   6'd3,  32'h0);
        send_request(MODE_ERASE,   6'd0,  32'h0);
        send_request(MODE_SPARE_A, 6'd63, 32'hFFFF_FFFF);
        send_request(MODE_SPARE_B, 6'd0,  32'h0);
        send_request(MODE_SPARE_C, 6'd21, 32'hA5A5_A5A5);
        send_request(MODE_POP,     6'd0,  32'h0);
        send_request(MODE_CLEAR,   6'd63, 32'hFFFF_FFFF);
        send_request(MODE_POP,     6'd0,  32'h0);
        send_request(MODE_PUSH,    6'd0,  32'h5555_5555);
        send_request(MODE_PUSH,    6'd0,  32'hAAAA_AAAA);
        send_request(MODE_POP,     6'd0,  32'h0);
        send_request(MODE_POP,     6'd0,  32'h0);
    endtask

    // fill to capacity and hit the full and boundary cases
    task automatic test_full_list();
        while (list_fill < DEPTH)
            send_request(MODE_PUSH, POS_W'($urandom), pick_word());
        send_request(MODE_PUSH,   6'd0,  pick_word());
        send_request(MODE_INSERT, 6'd0,  pick_word());
        send_request(MODE_INSERT, 6'd63, pick_word());
        send_request(MODE_ERASE,  6'd63, 32'h0);
        send_request(MODE_INSERT, 6'd62, pick_word());
        send_request(MODE_ERASE,  6'd0,  32'h0);
        send_request(MODE_POP,    6'd0,  32'h0);
        send_request(MODE_CLEAR,  6'd0,  32'h0);
    endtask

    // random mix, alternating between growing and shrinking the list
    task automatic test_random_ops(input int n_items);
        int                  phase_left;
        bit                  growing;
        int                  r;
        logic [MODE_W-1:0]   mode;
        phase_left = 0;
        growing    = 1'b0;
        for (int i = 0; i < n_items; i++) begin
            if (phase_left == 0) begin
                growing    = !growing;
                phase_left = $urandom_range(40, 160);
            end else begin
                phase_left--;
            end
            r = $urandom_range(0, 199);
            if (r < 2)
                mode = MODE_CLEAR;
            else if (r < 8)
                mode = MODE_SPARE_A + MODE_W'($urandom_range(0, 2));
            else if (growing)
                mode = (r < 90)  ? MODE_PUSH :
                       (r < 150) ? MODE_INSERT :
                       (r < 175) ? MODE_POP : MODE_ERASE;
            else
                mode = (r < 30)  ? MODE_PUSH :
                       (r < 55)  ? MODE_INSERT :
                       (r < 130) ? MODE_POP : MODE_ERASE;
            send_request(mode, pick_position(), pick_word());
        end
    endtask

    // wait for every predicted result, then idle before returning
    task automatic drain_results();
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_MAX) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        repeat (TAIL_WAIT) @(negedge i_clk);
    endtask

    // receiver stall pattern: runs of always-ready, random, sparse and toggling
    always @(negedge i_clk) begin
        if (ready_phase_left == 0) begin
            ready_phase      = $urandom_range(0, 3);
            ready_phase_left = $urandom_range(20, 150);
        end else begin
            ready_phase_left--;
        end
        case (ready_phase)
            0:       i_m_tready = 1'b1;
            1:       i_m_tready = 1'($urandom_range(0, 1));
            2:       i_m_tready = ($urandom_range(0, 3) == 0);
            default: i_m_tready = ~i_m_tready;
        endcase
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        t_list_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.word   = o_m_tdata[WORD_W-1:0];
            got.count  = o_m_tdata[WORD_W +: COUNT_W];
            got.status = o_m_tdata[WORD_W+COUNT_W +: STATUS_W];
            if (pending_results.size() == 0) begin
                $error("result with nothing predicted: word %0d count %0d status %0d",
                       got.word, got.count, got.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.word !== want.word) begin
                    $error("word_out: expected %0d, got %0d", want.word, got.word);
                    mismatch_count++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    mismatch_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // main sequence
    initial begin
        list_fill        = 0;
        mismatch_count   = 0;
        full_hits        = 0;
        burst_left       = 0;
        ready_phase      = 0;
        ready_phase_left = 0;
        foreach (mode_hits[m]) mode_hits[m] = 0;
        foreach (status_hits[s]) status_hits[s] = 0;
        foreach (list_words[k]) list_words[k] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_full_list();
        test_random_ops(1560);
        drain_results();

        $display("requests by mode: push %0d pop %0d insert %0d erase %0d clear %0d spare %0d",
                 mode_hits[MODE_PUSH], mode_hits[MODE_POP], mode_hits[MODE_INSERT],
                 mode_hits[MODE_ERASE], mode_hits[MODE_CLEAR],
                 mode_hits[MODE_SPARE_A] + mode_hits[MODE_SPARE_B] + mode_hits[MODE_SPARE_C]);
        $display("statuses: ok %0d full %0d empty %0d bad index %0d, list filled %0d times",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_INDEX], full_hits);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ieel_pkg.sv
hdl/ieel_cell.sv
hdl/indexed_insert_erase_list.sv
hdl/ieel_checker.sv
tb/sv/tb.sv
